@@ src/lts_pkg.sv @@
// Shared types, codes and character tables for the language token scanner.
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

   localparam int OFFSET_BITS_DEF = 24;
   localparam int KEYWORD_MAX_LEN = 8;
   localparam int FIELD_W         = 24;
   localparam int DEPTH_W         = 16;
   localparam int IDENT_W         = 8 * KEYWORD_MAX_LEN;

   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

   typedef enum logic [5:0] {
      TK_END = 6'd0, TK_BAD_CHAR, TK_UNTERM_STRING,
      TK_LPAREN, TK_RPAREN, TK_LSQUARE, TK_RSQUARE, TK_COLON, TK_COMMA,
      TK_DOT, TK_MINUS, TK_PLUS, TK_QUESTION, TK_SEMI, TK_SLASH, TK_STAR,
      TK_NEWLINE, TK_BANG, TK_BANG_EQ, TK_EQ, TK_EQ_EQ, TK_GT, TK_GT_EQ,
      TK_LT, TK_LT_EQ, TK_IDENT, TK_STRING, TK_INTEGER, TK_FLOAT,
      TK_KW_AND, TK_KW_ASSOC, TK_KW_BLOCK, TK_KW_BREAK, TK_KW_CLASS,
      TK_KW_CONST, TK_KW_CONTINUE, TK_KW_EACH, TK_KW_ELSE, TK_KW_END,
      TK_KW_FALSE, TK_KW_FUN, TK_KW_FOR, TK_KW_GIVEN, TK_KW_IF, TK_KW_IN,
      TK_KW_IS, TK_KW_NIL, TK_KW_OR, TK_KW_REF, TK_KW_RETURN, TK_KW_STRUCT,
      TK_KW_THIS, TK_KW_TRAIT, TK_KW_TRUE, TK_KW_VAR, TK_KW_WHEN, TK_KW_WHILE
   } token_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_SLASH, MODE_COMMENT, MODE_IDENT, MODE_INT, MODE_FLOAT,
      MODE_STRING, MODE_BANG, MODE_EQ, MODE_GT, MODE_LT
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      token_kind_type            token_kind;
      logic [FIELD_W-1:0]        start_offset;
      logic [FIELD_W-1:0]        token_length;
      logic [FIELD_W-1:0]        line_number;
      logic [7:0]                bad_char;
      logic signed [DEPTH_W-1:0] paren_depth;
      logic signed [DEPTH_W-1:0] square_depth;
      logic                      last_of_run;
   } rsp_type;

   // Scanner state apart from the offsets, whose width is a parameter.
   typedef struct packed {
      scan_mode_type             mode;
      logic [FIELD_W-1:0]        line;
      logic [IDENT_W-1:0]        ident;
      logic                      too_long;
      logic signed [DEPTH_W-1:0] round;
      logic signed [DEPTH_W-1:0] square;
   } state_type;

   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_SLASH    = "/";
   localparam logic [7:0] CH_BANG     = "!";
   localparam logic [7:0] CH_EQ       = "=";
   localparam logic [7:0] CH_GT       = ">";
   localparam logic [7:0] CH_LT       = "<";
   localparam logic [7:0] CH_DOT      = ".";
   localparam logic [7:0] CH_LPAREN   = "(";
   localparam logic [7:0] CH_RPAREN   = ")";
   localparam logic [7:0] CH_LSQUARE  = "[";
   localparam logic [7:0] CH_RSQUARE  = "]";
   localparam logic [7:0] CH_COLON    = ":";
   localparam logic [7:0] CH_COMMA    = ",";
   localparam logic [7:0] CH_MINUS    = "-";
   localparam logic [7:0] CH_PLUS     = "+";
   localparam logic [7:0] CH_QUESTION = "?";
   localparam logic [7:0] CH_SEMI     = ";";
   localparam logic [7:0] CH_STAR     = "*";

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   // Single-byte tokens; anything unlisted is a bad character.
   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         CH_LPAREN:   k = TK_LPAREN;
         CH_RPAREN:   k = TK_RPAREN;
         CH_LSQUARE:  k = TK_LSQUARE;
         CH_RSQUARE:  k = TK_RSQUARE;
         CH_COLON:    k = TK_COLON;
         CH_COMMA:    k = TK_COMMA;
         CH_DOT:      k = TK_DOT;
         CH_MINUS:    k = TK_MINUS;
         CH_PLUS:     k = TK_PLUS;
         CH_QUESTION: k = TK_QUESTION;
         CH_SEMI:     k = TK_SEMI;
         CH_STAR:     k = TK_STAR;
         CH_NL:       k = TK_NEWLINE;
         default:     k = TK_BAD_CHAR;
      endcase
      return k;
   endfunction

   function automatic token_kind_type keyword_kind(input logic [IDENT_W-1:0] chars,
                                                  input logic too_long);
      token_kind_type k;
      case (chars)
         IDENT_W'("and"):      k = TK_KW_AND;
         IDENT_W'("assoc"):    k = TK_KW_ASSOC;
         IDENT_W'("block"):    k = TK_KW_BLOCK;
         IDENT_W'("break"):    k = TK_KW_BREAK;
         IDENT_W'("class"):    k = TK_KW_CLASS;
         IDENT_W'("const"):    k = TK_KW_CONST;
         IDENT_W'("continue"): k = TK_KW_CONTINUE;
         IDENT_W'("each"):     k = TK_KW_EACH;
         IDENT_W'("else"):     k = TK_KW_ELSE;
         IDENT_W'("end"):      k = TK_KW_END;
         IDENT_W'("false"):    k = TK_KW_FALSE;
         IDENT_W'("fun"):      k = TK_KW_FUN;
         IDENT_W'("for"):      k = TK_KW_FOR;
         IDENT_W'("given"):    k = TK_KW_GIVEN;
         IDENT_W'("if"):       k = TK_KW_IF;
         IDENT_W'("in"):       k = TK_KW_IN;
         IDENT_W'("is"):       k = TK_KW_IS;
         IDENT_W'("nil"):      k = TK_KW_NIL;
         IDENT_W'("or"):       k = TK_KW_OR;
         IDENT_W'("ref"):      k = TK_KW_REF;
         IDENT_W'("return"):   k = TK_KW_RETURN;
         IDENT_W'("struct"):   k = TK_KW_STRUCT;
         IDENT_W'("this"):     k = TK_KW_THIS;
         IDENT_W'("trait"):    k = TK_KW_TRAIT;
         IDENT_W'("true"):     k = TK_KW_TRUE;
         IDENT_W'("var"):      k = TK_KW_VAR;
         IDENT_W'("when"):     k = TK_KW_WHEN;
         IDENT_W'("while"):    k = TK_KW_WHILE;
         default:              k = TK_IDENT;
      endcase
      if (too_long) begin
         k = TK_IDENT;
      end
      return k;
   endfunction

   // Kind of the token left open in a mode when a byte cannot extend it.
   function automatic token_kind_type flush_kind(input state_type st);
      token_kind_type k;
      case (st.mode)
         MODE_SLASH:  k = TK_SLASH;
         MODE_IDENT:  k = keyword_kind(st.ident, st.too_long);
         MODE_INT:    k = TK_INTEGER;
         MODE_FLOAT:  k = TK_FLOAT;
         MODE_BANG:   k = TK_BANG;
         MODE_EQ:     k = TK_EQ;
         MODE_GT:     k = TK_GT;
         MODE_LT:     k = TK_LT;
         MODE_STRING: k = TK_UNTERM_STRING;
         default:     k = TK_END;
      endcase
      return k;
   endfunction

   function automatic token_kind_type pair_kind(input scan_mode_type mode);
      token_kind_type k;
      case (mode)
         MODE_BANG: k = TK_BANG_EQ;
         MODE_EQ:   k = TK_EQ_EQ;
         MODE_GT:   k = TK_GT_EQ;
         MODE_LT:   k = TK_LT_EQ;
         default:   k = TK_END;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

@@ src/lts_scan.sv @@
// Combinational scan step: one word against the scanner state, up to two tokens out.
`timescale 1ns / 1ps
`default_nettype none

module lts_scan #(
   parameter int OFFSET_BITS = lts_pkg::OFFSET_BITS_DEF
) (
   input  lts_pkg::req_type   req,
   input  lts_pkg::state_type st_i,
   input  logic [OFFSET_BITS-1:0] start_i,
   input  logic [OFFSET_BITS-1:0] cur_i,
   output lts_pkg::state_type st_o,
   output logic [OFFSET_BITS-1:0] start_o,
   output logic [OFFSET_BITS-1:0] cur_o,
   output lts_pkg::rsp_type   res0_o,
   output lts_pkg::rsp_type   res1_o,
   output logic [1:0]         res_cnt_o
);
   import lts_pkg::*;

   function automatic logic [FIELD_W-1:0] sat_field(input logic [OFFSET_BITS-1:0] v);
      logic [32:0] ext;
      ext = 33'(v);
      return (ext > 33'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_W-1:0];
   endfunction

   logic [7:0]             c;
   logic [OFFSET_BITS-1:0] cur_inc;
   logic                   op_mode;
   logic                   pending;
   logic                   do_idle;
   logic                   idle_emit;
   logic                   emit_a;
   logic                   emit_b;
   token_kind_type         kind_b;
   logic [OFFSET_BITS-1:0] start_b;
   logic [OFFSET_BITS-1:0] len_b;
   logic [7:0]             bad_b;
   rsp_type                word_a;
   rsp_type                word_b;
   state_type              st_n;

   assign c       = req.char_byte;
   assign cur_inc = (cur_i == {OFFSET_BITS{1'b1}}) ? cur_i : cur_i + OFFSET_BITS'(1);
   assign op_mode = (st_i.mode == MODE_BANG) || (st_i.mode == MODE_EQ) ||
                    (st_i.mode == MODE_GT)   || (st_i.mode == MODE_LT);
   assign pending = (st_i.mode != MODE_IDLE) && (st_i.mode != MODE_COMMENT);

   // Byte is scanned from the idle mode, after any open token is closed.
   assign do_idle = !req.end_of_source && (
                       (st_i.mode == MODE_IDLE) ||
                       ((st_i.mode == MODE_COMMENT) && (c == CH_NL)) ||
                       ((st_i.mode == MODE_SLASH) && (c != CH_SLASH)) ||
                       ((st_i.mode == MODE_IDENT) && !is_ident_start(c) && !is_digit(c)) ||
                       ((st_i.mode == MODE_INT) && !is_digit(c) && (c != CH_DOT)) ||
                       ((st_i.mode == MODE_FLOAT) && !is_digit(c)) ||
                       (op_mode && (c != CH_EQ)));

   assign idle_emit = !is_space(c) && !is_digit(c) && !is_ident_start(c) &&
                      (c != CH_QUOTE) && (c != CH_SLASH) && (c != CH_BANG) &&
                      (c != CH_EQ) && (c != CH_GT) && (c != CH_LT);

   assign emit_a = pending && (req.end_of_source || do_idle);

   // Next state
   always_comb begin
      st_n    = st_i;
      start_o = start_i;
      cur_o   = cur_i;
      if (req.end_of_source) begin
         st_n.mode     = MODE_IDLE;
         st_n.line     = FIELD_W'(1);
         st_n.ident    = '0;
         st_n.too_long = 1'b0;
         st_n.round    = '0;
         st_n.square   = '0;
         start_o       = '0;
         cur_o         = '0;
      end else if (do_idle) begin
         st_n.mode = MODE_IDLE;
         start_o   = cur_i;
         cur_o     = cur_inc;
         if (is_digit(c)) begin
            st_n.mode = MODE_INT;
         end else if (is_ident_start(c)) begin
            st_n.mode     = MODE_IDENT;
            st_n.ident    = IDENT_W'(c);
            st_n.too_long = 1'b0;
         end else begin
            case (c)
               CH_QUOTE:   st_n.mode = MODE_STRING;
               CH_SLASH:   st_n.mode = MODE_SLASH;
               CH_BANG:    st_n.mode = MODE_BANG;
               CH_EQ:      st_n.mode = MODE_EQ;
               CH_GT:      st_n.mode = MODE_GT;
               CH_LT:      st_n.mode = MODE_LT;
               CH_LPAREN:  st_n.round  = st_i.round + 16'sd1;
               CH_RPAREN:  st_n.round  = st_i.round - 16'sd1;
               CH_LSQUARE: st_n.square = st_i.square + 16'sd1;
               CH_RSQUARE: st_n.square = st_i.square - 16'sd1;
               CH_NL: begin
                  if (st_i.line != FIELD_MAX) begin
                     st_n.line = st_i.line + FIELD_W'(1);
                  end
               end
               default: ;
            endcase
         end
      end else begin
         // Byte extends or completes the open token
         cur_o = cur_inc;
         case (st_i.mode)
            MODE_SLASH:  st_n.mode = MODE_COMMENT;
            MODE_IDENT: begin
               if (st_i.ident[IDENT_W-1 -: 8] != 8'd0) begin
                  st_n.too_long = 1'b1;
               end else begin
                  st_n.ident = {st_i.ident[IDENT_W-9:0], c};
               end
            end
            MODE_INT: begin
               if (c == CH_DOT) begin
                  st_n.mode = MODE_FLOAT;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  st_n.mode = MODE_IDLE;
               end
            end
            MODE_BANG, MODE_EQ, MODE_GT, MODE_LT: st_n.mode = MODE_IDLE;
            default: ;
         endcase
      end
   end

   assign st_o = st_n;

   // Outputs
   always_comb begin
      emit_b  = 1'b0;
      kind_b  = TK_END;
      start_b = cur_i;
      len_b   = '0;
      bad_b   = 8'd0;
      if (req.end_of_source) begin
         emit_b = 1'b1;
      end else if ((st_i.mode == MODE_STRING) && (c == CH_QUOTE)) begin
         emit_b  = 1'b1;
         kind_b  = TK_STRING;
         start_b = start_i;
         len_b   = cur_inc - start_i;
      end else if (op_mode && (c == CH_EQ)) begin
         emit_b  = 1'b1;
         kind_b  = pair_kind(st_i.mode);
         start_b = start_i;
         len_b   = cur_inc - start_i;
      end else if (do_idle && idle_emit) begin
         emit_b = 1'b1;
         kind_b = punct_kind(c);
         if (kind_b == TK_BAD_CHAR) begin
            len_b = OFFSET_BITS'(1);
            bad_b = c;
         end else begin
            len_b = cur_inc - cur_i;
         end
      end

      word_a.token_kind   = flush_kind(st_i);
      word_a.start_offset = sat_field(start_i);
      word_a.token_length = sat_field(cur_i - start_i);
      word_a.line_number  = st_i.line;
      word_a.bad_char     = 8'd0;
      word_a.paren_depth  = st_i.round;
      word_a.square_depth = st_i.square;
      word_a.last_of_run  = !emit_b;

      word_b.token_kind   = kind_b;
      word_b.start_offset = sat_field(start_b);
      word_b.token_length = sat_field(len_b);
      word_b.line_number  = req.end_of_source ? st_i.line   : st_n.line;
      word_b.bad_char     = bad_b;
      word_b.paren_depth  = req.end_of_source ? st_i.round  : st_n.round;
      word_b.square_depth = req.end_of_source ? st_i.square : st_n.square;
      word_b.last_of_run  = 1'b1;

      res0_o    = emit_a ? word_a : word_b;
      res1_o    = word_b;
      res_cnt_o = {1'b0, emit_a} + {1'b0, emit_b};
   end

endmodule

`default_nettype wire

@@ src/language_token_scanner_top.sv @@
// Top level of the language token scanner: state registers and a two-word result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer. Feed source text one byte per req word and close it
// with a word that has end_of_source set; the scanner then returns to its
// reset state, so the next source can follow at once. Each token leaves on
// the rsp channel with its kind, start offset, length, line and bracket
// depths; last_of_run marks the final token caused by one req word. A req
// word is scanned in the cycle it is accepted and its tokens are visible on
// rsp the next cycle. Throughput is one req word per cycle while rsp_ready
// is high and no word yields two tokens. The two-word result buffer has a
// single output port, so a word that closes one token and emits another
// (two tokens) keeps req_ready low while the second token drains. Words
// that only extend a token, and whitespace and comment bytes that close no
// token, produce no rsp word at all. Offsets are held at OFFSET_BITS bits
// and saturate; the reported fields saturate at 24 bits.
module language_token_scanner_top #(
   parameter int OFFSET_BITS = lts_pkg::OFFSET_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lts_pkg::rsp_type rsp_data
);
   import lts_pkg::*;

   // Scanner state
   state_type              st_ff;
   state_type              st_in;
   logic [OFFSET_BITS-1:0] start_ff;
   logic [OFFSET_BITS-1:0] start_in;
   logic [OFFSET_BITS-1:0] cur_ff;
   logic [OFFSET_BITS-1:0] cur_in;

   // Result buffer: slot0 is on the port, slot1 waits behind it
   rsp_type    slot0_ff;
   rsp_type    slot0_in;
   rsp_type    slot1_ff;
   rsp_type    slot1_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   rsp_type    res0;
   rsp_type    res1;
   logic [1:0] res_cnt;
   logic       req_take;
   logic       rsp_take;

   lts_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .req       (req_data),
      .st_i      (st_ff),
      .start_i   (start_ff),
      .cur_i     (cur_ff),
      .st_o      (st_in),
      .start_o   (start_in),
      .cur_o     (cur_in),
      .res0_o    (res0),
      .res1_o    (res1),
      .res_cnt_o (res_cnt)
   );

   // Take a new word whenever the buffer will be empty after this cycle
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (req_take) begin
         // Load fresh tokens; any word on the port is leaving this cycle
         slot0_in = res0;
         slot1_in = res1;
         cnt_in   = res_cnt;
      end else if (rsp_take) begin
         // Advance the waiting token to the port
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode     <= MODE_IDLE;
         st_ff.line     <= FIELD_W'(1);
         st_ff.ident    <= '0;
         st_ff.too_long <= 1'b0;
         st_ff.round    <= '0;
         st_ff.square   <= '0;
         start_ff       <= '0;
         cur_ff         <= '0;
         cnt_ff         <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_take) begin
            st_ff    <= st_in;
            start_ff <= start_in;
            cur_ff   <= cur_in;
         end
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef ASSERT_OFF
   // The buffer never holds more than two tokens
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   // End of source returns the scanner to its reset state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.end_of_source) |=>
         (cur_ff == '0) && (start_ff == '0) && (st_ff.mode == MODE_IDLE) &&
         (st_ff.line == FIELD_W'(1)))
      else $error("scanner state not cleared after end of source");

   // End of source always yields at least the end token
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.end_of_source) |=> rsp_valid)
      else $error("no token after end of source");

   // A lone buffered token is always the last of its run
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> rsp_data.last_of_run)
      else $error("single buffered token not marked last of run");
`endif

endmodule

`default_nettype wire
